### hw/rtl/hpti_pkg.sv
// ----------------------------------------------------------------------------
// hpti_pkg
// Shared constants, entry layout and controller/datapath interface types for
// the hashed page table insert block.
// ----------------------------------------------------------------------------
package hpti_pkg;

  // table geometry; slots per group must be a power of two
  localparam int GROUP_BITS      = 10;
  localparam int SLOTS_PER_GROUP = 8;
  localparam int SLOT_W          = $clog2(SLOTS_PER_GROUP);
  localparam int ROWS            = 1 << GROUP_BITS;

  // item field widths
  localparam int VA_W   = 32;
  localparam int SID_W  = 24;
  localparam int PPN_W  = 20;
  localparam int PAGE_W = 16;
  localparam int API_W  = 6;
  localparam int PAGE_LSB = 12;
  localparam int API_LSB  = 22;

  // result field widths
  localparam int GRP_OUT_W  = 10;
  localparam int SLOT_OUT_W = 3;
  localparam int OUTC_W     = 2;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  // entry: valid sid h api ppn r c pp (msb first)
  localparam int ENTRY_W  = 56;
  localparam int E_VALID  = 55;
  localparam int E_SID_LSB = 31;
  localparam int E_API_LSB = 24;
  localparam logic [1:0] PROT_VALUE = 2'd2;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_FREE  = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_MATCH = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

  typedef logic [SLOTS_PER_GROUP-1:0][ENTRY_W-1:0] row_t;

  typedef struct packed {
    logic load_item;  // capture input item
    logic rd_en;      // read a group row
    logic rd_sec;     // row address is the secondary group
    logic clear;      // zero one row during the clear sweep
    logic commit;     // write entry and load result register
    logic use_sec;    // commit into secondary group
    logic evict;      // commit overwrites primary slot page mod slots
  } dp_cmd_t;

  typedef struct packed {
    logic hit;        // registered row has a usable slot
    logic clr_last;   // clear sweep at its last row
    logic out_free;   // result register can take a new item
  } dp_stat_t;

endpackage

### hw/rtl/hashed_page_table_insert_top.sv
// Result: out_tvalid rises once the commit in S_CHK_PRI is registered on a
//   primary-group insert, or the commit in S_CHK_SEC when the secondary group is read.
// Items: one at a time; accept, then one row read and one check per group
//   searched; a stalled result holds the block in its check.
// Reset: the table is zeroed by a sweep of all 1024 rows, one group row per cycle;
//   in_tready stays low until it ends.
// ----------------------------------------------------------------------------
// hashed_page_table_insert_top
// Inserts a translation into a hashed page table of 8-entry groups and
// reports the group, slot and kind of replacement.
// ----------------------------------------------------------------------------
module hashed_page_table_insert_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // virt_addr[31:0], segment_id[55:32], phys_page[75:56], zero[79:76]
  input  logic [hpti_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // group_index[9:0], slot_index[12:10], used_secondary[13], outcome[15:14]
  output logic [hpti_pkg::OUT_DATA_W-1:0]  out_tdata
);

  hpti_pkg::dp_cmd_t  cmd;
  hpti_pkg::dp_stat_t stat;

  hpti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hpti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/hpti_dp.sv
// ----------------------------------------------------------------------------
// hpti_dp
// Datapath: item registers, hash, group-row memory, slot search, entry write
// and the result register.
// ----------------------------------------------------------------------------
module hpti_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hpti_pkg::dp_cmd_t                 cmd,
  output hpti_pkg::dp_stat_t                stat,
  input  logic [hpti_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hpti_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // item registers
  logic [hpti_pkg::VA_W-1:0]  va_r;
  logic [hpti_pkg::SID_W-1:0] sid_r;
  logic [hpti_pkg::PPN_W-1:0] ppn_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      va_r  <= in_tdata[hpti_pkg::VA_W-1:0];
      sid_r <= in_tdata[hpti_pkg::VA_W +: hpti_pkg::SID_W];
      ppn_r <= in_tdata[hpti_pkg::VA_W+hpti_pkg::SID_W +: hpti_pkg::PPN_W];
    end
  end

  logic [hpti_pkg::PAGE_W-1:0]     page;
  logic [hpti_pkg::API_W-1:0]      api;
  logic [hpti_pkg::SID_W-1:0]      hash;
  logic [hpti_pkg::GROUP_BITS-1:0] grp_pri;
  logic [hpti_pkg::GROUP_BITS-1:0] grp_sec;

  assign page    = va_r[hpti_pkg::PAGE_LSB +: hpti_pkg::PAGE_W];
  assign api     = va_r[hpti_pkg::API_LSB +: hpti_pkg::API_W];
  assign hash    = sid_r ^ hpti_pkg::SID_W'(page);
  assign grp_pri = hash[hpti_pkg::GROUP_BITS-1:0];
  assign grp_sec = ~grp_pri;

  // clear sweep counter
  logic [hpti_pkg::GROUP_BITS-1:0] clr_cnt_r;
  logic [hpti_pkg::GROUP_BITS-1:0] clr_cnt_nxt;

  assign clr_cnt_nxt = cmd.clear ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // slot search over the registered row
  hpti_pkg::row_t                  rd_row_r;
  logic [hpti_pkg::SLOTS_PER_GROUP-1:0] usable;
  logic [hpti_pkg::SLOT_W-1:0]     first_slot;
  logic                            first_valid;

  always_comb begin
    for (int s = 0; s < hpti_pkg::SLOTS_PER_GROUP; s++) begin
      usable[s] = !rd_row_r[s][hpti_pkg::E_VALID] ||
                  (rd_row_r[s][hpti_pkg::E_SID_LSB +: hpti_pkg::SID_W] == sid_r &&
                   rd_row_r[s][hpti_pkg::E_API_LSB +: hpti_pkg::API_W] == api);
    end
    first_slot = '0;
    for (int s = hpti_pkg::SLOTS_PER_GROUP - 1; s >= 0; s--) begin
      if (usable[s]) begin
        first_slot = hpti_pkg::SLOT_W'(s);
      end
    end
    first_valid = rd_row_r[first_slot][hpti_pkg::E_VALID];
  end

  // commit selection
  logic [hpti_pkg::GROUP_BITS-1:0] wr_grp;
  logic [hpti_pkg::SLOT_W-1:0]     wr_slot;
  logic [hpti_pkg::ENTRY_W-1:0]    wr_entry;
  logic [hpti_pkg::OUTC_W-1:0]     outcome;

  assign wr_grp   = cmd.use_sec ? grp_sec : grp_pri;
  assign wr_slot  = cmd.evict ? page[hpti_pkg::SLOT_W-1:0] : first_slot;
  assign wr_entry = {1'b1, sid_r, cmd.use_sec, api, ppn_r, 1'b0, 1'b0,
                     hpti_pkg::PROT_VALUE};
  assign outcome  = cmd.evict  ? hpti_pkg::OUTC_EVICT :
                    first_valid ? hpti_pkg::OUTC_MATCH : hpti_pkg::OUTC_FREE;

  // group-row memory, one slot written per commit, whole row zeroed on clear
  hpti_pkg::row_t mem [hpti_pkg::ROWS];
  logic [hpti_pkg::GROUP_BITS-1:0] rd_addr;

  assign rd_addr = cmd.rd_sec ? grp_sec : grp_pri;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.commit) begin
      mem[wr_grp][wr_slot] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  // result register
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [hpti_pkg::OUT_DATA_W-1:0]    out_data_r;

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {outcome, cmd.use_sec,
                     hpti_pkg::SLOT_OUT_W'(wr_slot),
                     hpti_pkg::GRP_OUT_W'(wr_grp)};
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.hit      = |usable;
  assign stat.clr_last = &clr_cnt_r;
  assign stat.out_free = ~out_valid_r | out_tready;

endmodule

### hw/rtl/hpti_ctrl.sv
// ----------------------------------------------------------------------------
// hpti_ctrl
// Controller: clear sweep after reset, primary then secondary group lookup,
// commit when the result register is free.
// ----------------------------------------------------------------------------
module hpti_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  hpti_pkg::dp_stat_t stat,
  output hpti_pkg::dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_RD_PRI  = 6'b000100,
    S_CHK_PRI = 6'b001000,
    S_RD_SEC  = 6'b010000,
    S_CHK_SEC = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_RD_PRI;
        end
      end
      S_RD_PRI: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHK_PRI;
      end
      S_CHK_PRI: begin
        if (!stat.hit) begin
          state_nxt = S_RD_SEC;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RD_SEC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sec = 1'b1;
        state_nxt  = S_CHK_SEC;
      end
      S_CHK_SEC: begin
        // no usable slot in either group: evict from the primary group
        if (stat.out_free) begin
          cmd.commit  = 1'b1;
          cmd.use_sec = stat.hit;
          cmd.evict   = ~stat.hit;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
